// ===== src/brq_pkg.sv =====
// ----------------------------------------------------------------------------
// brq_pkg
// Request codes and item types shared by the byte ring queue modules.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  localparam int unsigned FIELD_W = 10;
  localparam logic [FIELD_W-1:0] CHUNK_MAX = 10'h3FF;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         data_in;
    logic [FIELD_W-1:0] offset;
    logic               chunk_last;
  } brq_in_t;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               ok;
    logic [FIELD_W-1:0] used_count;
    logic [FIELD_W-1:0] free_count;
    logic [FIELD_W-1:0] chunk_count;
  } brq_out_t;

endpackage

// ===== src/brq_ram.sv =====
// ----------------------------------------------------------------------------
// brq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module brq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/byte_ring_queue_with_peek.sv =====
// ----------------------------------------------------------------------------
// byte_ring_queue_with_peek
// Byte ring FIFO holding at most DEPTH-1 bytes, with enqueue, dequeue and peek.
// ----------------------------------------------------------------------------
// The result of an item is strobed on out_valid in the cycle after start.
// Throughput: one item per cycle; each item makes a single access to the byte
// memory, and the registered read lines up with the result registers.
// Reset clears head, tail, fill level and chunk count; the byte store is not
// cleared, since only written bytes are ever read. The receiver cannot stall.
module byte_ring_queue_with_peek
  import brq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  brq_in_t  in_item,
  output logic     out_valid,
  output brq_out_t out_item
);

  localparam int unsigned AW = $clog2(DEPTH);
  // Wide enough for head + 1 + offset and for the field-width comparisons.
  localparam int unsigned CW = (AW > FIELD_W) ? AW + 1 : FIELD_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [AW-1:0]      used_r, used_nxt;
  logic [FIELD_W-1:0] chunk_r, chunk_nxt;

  logic               out_valid_r;
  logic               rd_sel_r;
  logic               ok_r;
  logic [FIELD_W-1:0] used_cnt_r, free_cnt_r, chunk_cnt_r;

  logic               accept;
  logic [AW-1:0]      head_inc, tail_inc, peek_pos;
  logic [CW-1:0]      pos_sum, off_ext, used_ext;
  logic [CW-1:0]      used_nxt_ext, free_nxt_ext;
  logic               done, is_read;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_rdata;
  logic [FIELD_W-1:0] chunk_inc;

  // The block never holds off an item: each takes one memory access.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;

  assign off_ext  = CW'(in_item.offset);
  assign used_ext = CW'(used_r);
  // offset < used < DEPTH, so a single subtract brings the sum into range.
  assign pos_sum  = CW'(head_r) + CW'(1) + off_ext;
  assign peek_pos = (pos_sum >= CW'(DEPTH)) ? AW'(pos_sum - CW'(DEPTH)) : AW'(pos_sum);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    used_nxt = used_r;
    done     = 1'b0;
    is_read  = 1'b0;
    ram_we   = 1'b0;
    ram_addr = peek_pos;
    unique case (in_item.req_type)
      REQ_ENQ: begin
        ram_addr = tail_inc;
        if (used_r != LAST_IDX) begin
          done     = 1'b1;
          ram_we   = accept;
          tail_nxt = tail_inc;
          used_nxt = used_r + 1'b1;
        end
      end
      REQ_DEQ: begin
        ram_addr = head_inc;
        if (used_r != '0) begin
          done     = 1'b1;
          is_read  = 1'b1;
          head_nxt = head_inc;
          used_nxt = used_r - 1'b1;
        end
      end
      REQ_PEEK: begin
        ram_addr = peek_pos;
        if (off_ext < used_ext) begin
          done    = 1'b1;
          is_read = 1'b1;
        end
      end
      default: begin
        ram_addr = peek_pos;
      end
    endcase
  end

  assign chunk_inc = (done && chunk_r != CHUNK_MAX) ? chunk_r + 1'b1 : chunk_r;
  assign chunk_nxt = in_item.chunk_last ? '0 : chunk_inc;

  assign used_nxt_ext = CW'(used_nxt);
  assign free_nxt_ext = CW'(LAST_IDX - used_nxt);

  brq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_item.data_in),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        used_r  <= used_nxt;
        chunk_r <= chunk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_sel_r    <= is_read;
      ok_r        <= done;
      used_cnt_r  <= used_nxt_ext[FIELD_W-1:0];
      free_cnt_r  <= free_nxt_ext[FIELD_W-1:0];
      chunk_cnt_r <= in_item.chunk_last ? chunk_inc : '0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item.data_out    = rd_sel_r ? ram_rdata : 8'h00;
  assign out_item.ok          = ok_r;
  assign out_item.used_count  = used_cnt_r;
  assign out_item.free_count  = free_cnt_r;
  assign out_item.chunk_count = chunk_cnt_r;

endmodule

// ===== tb/byte_ring_queue_with_peek_test.sv =====
// ----------------------------------------------------------------------------
// byte_ring_queue_with_peek_test
// Self-checking bench for the byte ring queue. Byte operations are sent with
// random sender gaps. An in-bench model of the ring predicts every result, and
// a checker compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_ring_queue_with_peek_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brq_pkg::*;

  localparam int unsigned RING_SLOTS = 1024;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned SHOW_LIMIT = 10;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  brq_in_t  in_item;
  logic     out_valid;
  brq_out_t out_item;

  // Model of the ring: storage, indexes and the running chunk tally.
  logic [7:0]         ring_bytes [RING_SLOTS];
  int unsigned        ring_head;
  int unsigned        ring_tail;
  logic [FIELD_W-1:0] chunk_tally;

  brq_out_t    pending_results[$];
  int unsigned error_count;
  int unsigned sender_idle_pct;

  byte_ring_queue_with_peek u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned ring_level();
    return (ring_tail + RING_SLOTS - ring_head) % RING_SLOTS;
  endfunction

  // Applies one byte operation to the model and returns its result.
  function automatic brq_out_t apply_byte_op(brq_in_t op);
    brq_out_t    res;
    int unsigned level;
    logic        done;
    level = ring_level();
    done  = 1'b0;
    res   = '0;
    case (op.req_type)
      REQ_ENQ: begin
        if (level < RING_SLOTS - 1) begin
          ring_tail = (ring_tail + 1) % RING_SLOTS;
          ring_bytes[ring_tail] = op.data_in;
          done = 1'b1;
        end
      end
      REQ_DEQ: begin
        if (level != 0) begin
          ring_head = (ring_head + 1) % RING_SLOTS;
          res.data_out = ring_bytes[ring_head];
          done = 1'b1;
        end
      end
      REQ_PEEK: begin
        if (op.offset < level) begin
          res.data_out = ring_bytes[(ring_head + 1 + op.offset) % RING_SLOTS];
          done = 1'b1;
        end
      end
      default: ;
    endcase
    if (done && chunk_tally != CHUNK_MAX) chunk_tally = chunk_tally + 1'b1;
    level = ring_level();
    res.ok         = done;
    res.used_count = FIELD_W'(level);
    res.free_count = FIELD_W'(RING_SLOTS - 1 - level);
    if (op.chunk_last) begin
      res.chunk_count = chunk_tally;
      chunk_tally     = '0;
    end
    return res;
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= SHOW_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  // Drives one item at a falling edge and holds it until the block takes it.
  task automatic send_byte_op(input logic [1:0] req, input logic [7:0] data,
                              input logic [FIELD_W-1:0] offs, input logic last);
    brq_in_t op;
    op.req_type   = req;
    op.data_in    = data;
    op.offset     = offs;
    op.chunk_last = last;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_byte_op(op));
  endtask

  always @(posedge clk) begin : result_check
    brq_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %p", out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.data_out !== want.data_out || out_item.ok !== want.ok ||
            out_item.used_count !== want.used_count ||
            out_item.free_count !== want.free_count ||
            out_item.chunk_count !== want.chunk_count) begin
          note_failure($sformatf("mismatch: expected %p, got %p", want, out_item));
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_byte_op(REQ_DEQ, 8'h5A, '0, 1'b1);
    send_byte_op(REQ_PEEK, 8'h00, '0, 1'b0);
    send_byte_op(REQ_PEEK, 8'hFF, 10'h3FF, 1'b0);
    send_byte_op(REQ_UNUSED, 8'hFF, 10'h3FF, 1'b1);
  endtask

  task automatic test_byte_extremes();
    send_byte_op(REQ_ENQ, 8'h00, '0, 1'b0);
    send_byte_op(REQ_ENQ, 8'hFF, 10'h3FF, 1'b0);
    send_byte_op(REQ_ENQ, 8'hA5, '0, 1'b1);
    send_byte_op(REQ_PEEK, 8'h00, 10'd0, 1'b0);
    send_byte_op(REQ_PEEK, 8'h00, 10'd2, 1'b0);
    send_byte_op(REQ_PEEK, 8'h00, 10'd3, 1'b0);
    send_byte_op(REQ_PEEK, 8'h00, 10'd1022, 1'b1);
    send_byte_op(REQ_UNUSED, 8'h00, '0, 1'b0);
    repeat (3) send_byte_op(REQ_DEQ, 8'h00, '0, 1'b0);
    send_byte_op(REQ_DEQ, 8'h00, '0, 1'b1);
  endtask

  // Filling the ring in one chunk also drives the chunk tally into saturation.
  task automatic test_fill_and_saturate();
    repeat (RING_SLOTS - 1) send_byte_op(REQ_ENQ, 8'($urandom), '0, 1'b0);
    send_byte_op(REQ_ENQ, 8'($urandom), '0, 1'b0);
    send_byte_op(REQ_PEEK, 8'h00, 10'd1022, 1'b0);
    send_byte_op(REQ_PEEK, 8'h00, 10'd0, 1'b0);
    send_byte_op(REQ_ENQ, 8'h3C, '0, 1'b1);
  endtask

  task automatic test_drain_wrap();
    repeat (RING_SLOTS - 2) send_byte_op(REQ_DEQ, 8'h00, '0, 1'b0);
    send_byte_op(REQ_DEQ, 8'h00, '0, 1'b1);
    send_byte_op(REQ_DEQ, 8'h00, '0, 1'b0);
  endtask

  // Mixed traffic; the enqueue share drops as the ring fills so the level wanders.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    int unsigned        pick;
    int unsigned        level;
    int unsigned        enq_share;
    logic [1:0]         req;
    logic [FIELD_W-1:0] offs;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      level     = ring_level();
      enq_share = (level > 60) ? 30 : 45;
      pick      = $urandom_range(99);
      if (pick < 3) req = REQ_UNUSED;
      else if (pick < 3 + enq_share) req = REQ_ENQ;
      else if (pick < 75) req = REQ_DEQ;
      else req = REQ_PEEK;
      if (level != 0 && $urandom_range(4) != 0) offs = FIELD_W'($urandom_range(level - 1));
      else offs = FIELD_W'($urandom);
      send_byte_op(req, 8'($urandom), offs, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    ring_head       = 0;
    ring_tail       = 0;
    chunk_tally     = '0;
    error_count     = 0;
    sender_idle_pct = 0;
    foreach (ring_bytes[i]) ring_bytes[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 13;
    test_empty_queue();
    test_byte_extremes();
    test_fill_and_saturate();
    test_drain_wrap();
    test_random_traffic(13, 250);
    test_random_traffic(52, 250);
    test_random_traffic(0, 250);

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_ring_queue_with_peek_test: done, clean");
    end else begin
      $display("byte_ring_queue_with_peek_test: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("byte_ring_queue_with_peek_test: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/brq_pkg.sv
src/brq_ram.sv
src/byte_ring_queue_with_peek.sv
tb/byte_ring_queue_with_peek_test.sv
